// ----- design/lsm_pkg.sv -----
package lsm_pkg;

  localparam int LAYER_COUNT_DEF = 16;

  // Heights and ranges are carried at a width that covers every legal pool
  // size plus the signed 6-bit request.
  localparam int HT_W = 10;
  // Slot numbers at a width that covers every legal pool size.
  localparam int ID_W = 8;

  localparam logic SLOT_TAKEN = 1'b1;

  localparam logic signed [HT_W-1:0] H_NEG1 = '1;
  localparam logic signed [HT_W-1:0] H_ZERO = '0;
  localparam logic signed [HT_W-1:0] H_ONE  = HT_W'(1);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_SET   = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Stack cell control: a cell at height h takes its lower neighbor when h
  // lies in the below range, its upper neighbor when h lies in the above
  // range, and the moved layer when h equals put_h.
  typedef struct packed {
    logic signed [HT_W-1:0] below_lo;
    logic signed [HT_W-1:0] below_hi;
    logic signed [HT_W-1:0] above_lo;
    logic signed [HT_W-1:0] above_hi;
    logic signed [HT_W-1:0] put_h;
  } stk_ctrl_t;

  // Slot cell control: layers whose height lies in the inc range move up by
  // one, those in the dec range move down by one; the target slot is
  // claimed, given a new height or released.
  typedef struct packed {
    logic signed [HT_W-1:0] inc_lo;
    logic signed [HT_W-1:0] inc_hi;
    logic signed [HT_W-1:0] dec_lo;
    logic signed [HT_W-1:0] dec_hi;
    logic [ID_W-1:0]        tgt;
    logic signed [HT_W-1:0] tgt_h;
    logic                   claim;
    logic                   set_h;
    logic                   release_slot;
  } slot_ctrl_t;

endpackage

// ----- design/lsm_stack_cell.sv -----
module lsm_stack_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic              clk,
  input  lsm_pkg::stk_ctrl_t ctrl,
  input  logic [IW-1:0]     put_id,
  input  logic [IW-1:0]     from_below,
  input  logic [IW-1:0]     from_above,
  output logic [IW-1:0]     entry
);
  import lsm_pkg::*;

  localparam logic signed [HT_W-1:0] H = HT_W'(IDX);

  logic take_put;
  logic take_below;
  logic take_above;

  assign take_put   = (ctrl.put_h == H);
  assign take_below = (H >= ctrl.below_lo) && (H <= ctrl.below_hi);
  assign take_above = (H >= ctrl.above_lo) && (H <= ctrl.above_hi);

  // Entries above the top are never read, so the stack needs no reset.
  always_ff @(posedge clk) begin
    priority if (take_put) begin
      entry <= put_id;
    end else if (take_below) begin
      entry <= from_below;
    end else if (take_above) begin
      entry <= from_above;
    end
  end

endmodule

// ----- design/lsm_slot_cell.sv -----
module lsm_slot_cell #(
  parameter int IDX = 0,
  parameter int HW  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lsm_pkg::slot_ctrl_t   ctrl,
  output logic                  in_use,
  output logic signed [HW-1:0]  height
);
  import lsm_pkg::*;

  logic                   hit;
  logic signed [HT_W-1:0] h_w;
  logic                   do_inc;
  logic                   do_dec;

  assign hit    = (ctrl.tgt == ID_W'(IDX));
  assign h_w    = HT_W'(height);
  assign do_inc = (h_w >= ctrl.inc_lo) && (h_w <= ctrl.inc_hi);
  assign do_dec = (h_w >= ctrl.dec_lo) && (h_w <= ctrl.dec_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
      height <= '1;
    end else if (hit && (ctrl.claim || ctrl.set_h)) begin
      if (ctrl.claim) begin
        in_use <= SLOT_TAKEN;
        height <= '1;
      end else begin
        height <= HW'(ctrl.tgt_h);
        if (ctrl.release_slot) begin
          in_use <= 1'b0;
        end
      end
    end else if (do_inc) begin
      height <= HW'(h_w + H_ONE);
    end else if (do_dec) begin
      height <= HW'(h_w - H_ONE);
    end
  end

endmodule

// ----- design/layer_stack_manager.sv -----
// Z-order stack for a pool of LAYER_COUNT display layers. A command is taken
// when start is high and busy is low; it runs in two steps: the first
// registers the command together with the layer's current height and the
// lowest free slot, the second moves every layer in the stack at once, one
// stack cell per height shifting from its neighbor and one slot cell per layer
// renumbering its own height. The single result appears with done high for one
// cycle, the same cycle in which busy falls, and cannot be stalled by the receiver; a
// new command may be started in that same cycle. top_height always reports the
// stack top after the command.
module layer_stack_manager #(
  parameter int LAYER_COUNT = lsm_pkg::LAYER_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        mode,
  input  logic [3:0]        layer_id,
  input  logic signed [5:0] req_height,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status,
  output logic [3:0]        result_layer,
  output logic signed [4:0] final_height,
  output logic signed [4:0] top_height
);
  import lsm_pkg::*;

  localparam int IW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int HW = IW + 1;

  state_t state;
  state_t state_next;

  logic                   cmd_valid;
  logic                   cmd_found;
  logic [1:0]             cmd_mode;
  logic [3:0]             cmd_id;
  logic [IW-1:0]          cmd_slot;
  logic signed [HT_W-1:0] cmd_req;
  logic signed [HT_W-1:0] cmd_old;
  logic signed [HW-1:0]   top;

  logic [IW-1:0]        stack_q [LAYER_COUNT];
  logic                 slot_use [LAYER_COUNT];
  logic signed [HW-1:0] slot_h [LAYER_COUNT];

  logic          accept;
  logic          exec;
  logic          free_found;
  logic [IW-1:0] free_slot;
  logic [IW-1:0] look_idx;
  logic          look_valid;

  stk_ctrl_t              stk_ctrl;
  slot_ctrl_t             slot_ctrl;
  logic signed [HT_W-1:0] top_next;
  logic signed [HT_W-1:0] nh;
  logic                   is_set;
  logic                   read_ok;
  logic [IW-1:0]          read_val;

  assign accept = start && !busy;
  assign exec   = (state == S_EXEC);
  assign busy   = exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Lowest free slot; the scan runs downward so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = LAYER_COUNT - 1; i >= 0; i--) begin
      if (!slot_use[i]) begin
        free_found = 1'b1;
        free_slot  = IW'(i);
      end
    end
  end

  assign look_idx   = IW'(layer_id);
  assign look_valid = (int'(layer_id) < LAYER_COUNT) && slot_use[look_idx];

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode  <= mode;
      cmd_id    <= layer_id;
      cmd_req   <= HT_W'(req_height);
      cmd_old   <= HT_W'(slot_h[look_idx]);
      cmd_valid <= look_valid;
      cmd_slot  <= free_slot;
      cmd_found <= free_found;
    end
  end

  always_comb begin
    logic signed [HT_W-1:0] top_w;
    logic signed [HT_W-1:0] lim;
    logic signed [HT_W-1:0] nh_set;
    logic signed [HT_W-1:0] x_end;
    logic signed [HT_W-1:0] y_end;
    logic                   is_free;
    logic                   move;
    logic                   raise;
    logic                   lower;

    top_w   = HT_W'(top);
    lim     = (cmd_old >= H_ZERO) ? top_w : top_w + H_ONE;
    if (cmd_req > lim) begin
      nh_set = lim;
    end else if (cmd_req < H_NEG1) begin
      nh_set = H_NEG1;
    end else begin
      nh_set = cmd_req;
    end

    is_set  = exec && (cmd_mode == MODE_SET) && cmd_valid;
    is_free = exec && (cmd_mode == MODE_FREE) && cmd_valid;
    nh      = is_free ? H_NEG1 : nh_set;
    move    = (is_set || is_free) && (nh != cmd_old);

    // Raise: the moved layer lands below others, which rise by one.
    raise = move && (nh >= H_ZERO) && ((cmd_old < H_ZERO) || (cmd_old > nh));
    x_end = (cmd_old < H_ZERO) ? top_w + H_ONE : cmd_old;
    // Lower: layers above the old place fall by one.
    lower = move && (cmd_old >= H_ZERO) && ((nh < H_ZERO) || (nh > cmd_old));
    y_end = (nh < H_ZERO) ? top_w : nh;

    stk_ctrl.below_lo = raise ? nh + H_ONE : H_ZERO;
    stk_ctrl.below_hi = raise ? x_end : H_NEG1;
    stk_ctrl.above_lo = lower ? cmd_old : H_ZERO;
    stk_ctrl.above_hi = lower ? y_end - H_ONE : H_NEG1;
    stk_ctrl.put_h    = (move && (nh >= H_ZERO)) ? nh : H_NEG1;

    slot_ctrl.inc_lo       = raise ? nh : H_ZERO;
    slot_ctrl.inc_hi       = raise ? x_end - H_ONE : H_NEG1;
    slot_ctrl.dec_lo       = lower ? cmd_old + H_ONE : H_ZERO;
    slot_ctrl.dec_hi       = lower ? y_end : H_NEG1;
    slot_ctrl.tgt          = (cmd_mode == MODE_ALLOC) ? ID_W'(cmd_slot) : ID_W'(cmd_id);
    slot_ctrl.tgt_h        = nh;
    slot_ctrl.claim        = exec && (cmd_mode == MODE_ALLOC) && cmd_found;
    slot_ctrl.set_h        = is_set || is_free;
    slot_ctrl.release_slot = is_free;

    top_next = top_w;
    if (move && (cmd_old < H_ZERO)) begin
      top_next = top_w + H_ONE;
    end else if (move && (nh < H_ZERO)) begin
      top_next = top_w - H_ONE;
    end
  end

  assign read_ok  = (cmd_req >= H_ZERO) && (cmd_req <= HT_W'(top));
  assign read_val = stack_q[cmd_req[IW-1:0]];

  for (genvar i = 0; i < LAYER_COUNT; i++) begin : g_cells
    logic [IW-1:0] below_val;
    logic [IW-1:0] above_val;

    if (i == 0) begin : g_bot
      assign below_val = '0;
    end else begin : g_mid_b
      assign below_val = stack_q[i-1];
    end
    if (i == LAYER_COUNT - 1) begin : g_top
      assign above_val = '0;
    end else begin : g_mid_a
      assign above_val = stack_q[i+1];
    end

    lsm_stack_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_stack (
      .clk        (clk),
      .ctrl       (stk_ctrl),
      .put_id     (IW'(cmd_id)),
      .from_below (below_val),
      .from_above (above_val),
      .entry      (stack_q[i])
    );

    lsm_slot_cell #(
      .IDX (i),
      .HW  (HW)
    ) u_slot (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (slot_ctrl),
      .in_use (slot_use[i]),
      .height (slot_h[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top  <= '1;
      done <= 1'b0;
    end else begin
      done <= exec;
      if (exec) begin
        top <= HW'(top_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      top_height   <= 5'(top_next);
      result_layer <= '0;
      final_height <= '1;
      unique case (cmd_mode)
        MODE_ALLOC: begin
          status <= cmd_found ? ST_OK : ST_EMPTY;
          if (cmd_found) begin
            result_layer <= 4'(cmd_slot);
          end
        end
        MODE_SET: begin
          status <= cmd_valid ? ST_OK : ST_NOT_ALLOC;
          if (is_set) begin
            final_height <= 5'(nh);
          end
        end
        MODE_FREE: begin
          status <= cmd_valid ? ST_OK : ST_NOT_ALLOC;
        end
        MODE_READ: begin
          status <= read_ok ? ST_OK : ST_EMPTY;
          if (read_ok) begin
            result_layer <= 4'(read_val);
            final_height <= 5'(cmd_req);
          end
        end
      endcase
    end
  end

endmodule

// ----- design/lsm_checker.sv -----
module lsm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        mode,
  input logic [3:0]        layer_id,
  input logic signed [5:0] req_height,
  input logic [1:0]        status,
  input logic [3:0]        result_layer,
  input logic signed [4:0] final_height,
  input logic signed [4:0] top_height
);
  import lsm_pkg::*;

  // Every accepted item runs for exactly one busy cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("busy lasted more than one cycle or gave no result");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in flight");

  // Error results, including a failed alloc or lookup, carry no height and no layer.
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOT_ALLOC || status == ST_EMPTY)) |->
      (final_height == -5'sd1 && result_layer == 4'd0))
    else $error("error result carries layer or height");

  // Only a visible-layer change moves the top, and by at most one.
  a_top_step: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done, 2)) |->
      (top_height == $past(top_height, 2) ||
       top_height == $past(top_height, 2) + 5'sd1 ||
       top_height == $past(top_height, 2) - 5'sd1))
    else $error("top moved by more than one");

endmodule

bind layer_stack_manager lsm_checker u_lsm_checker (.*);

// ----- sim/layer_stack_checker.sv -----
module layer_stack_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        mode,
  input  logic [3:0]        layer_id,
  input  logic signed [5:0] req_height,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [3:0]        result_layer,
  input  logic signed [4:0] final_height,
  input  logic signed [4:0] top_height,
  output int                fail_count,
  output int                waiting,
  output int                checked,
  output int                peak_depth
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsm_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    status_t                st;
    logic [3:0]             lyr;
    logic signed [4:0]      fin_h;
    logic signed [4:0]      top_h;
  } answer_t;

  // Mirror of the layer pool: which slot sits at each height, each slot's
  // height (-1 when hidden), which slots are claimed, and the stack top.
  logic [3:0] z_order [SLOTS];
  int         slot_h  [SLOTS];
  bit         taken   [SLOTS];
  int         stack_top;

  answer_t    pending_answers [$];
  int         errs;
  int         n_checked;
  int         deepest;

  function automatic void put_at(int h, logic [3:0] id);
    z_order[h] = id;
    slot_h[id] = h;
  endfunction

  // Moves a claimed slot to the requested height after clamping and returns
  // the height it ends with.
  function automatic int restack(logic [3:0] id, int req);
    int old;
    int lim;
    int h;
    int r;
    old = slot_h[id];
    lim = (old >= 0) ? stack_top : stack_top + 1;
    r = req;
    if (r > lim) r = lim;
    if (r < -1) r = -1;
    if (old > r) begin
      if (r >= 0) begin
        for (h = old; h > r; h--) put_at(h, z_order[h-1]);
        put_at(r, id);
      end else begin
        for (h = old; h < stack_top; h++) put_at(h, z_order[h+1]);
        slot_h[id] = -1;
        stack_top--;
      end
    end else if (old < r) begin
      if (old >= 0) begin
        for (h = old; h < r; h++) put_at(h, z_order[h+1]);
        put_at(r, id);
      end else begin
        for (h = stack_top; h >= r; h--) put_at(h + 1, z_order[h]);
        put_at(r, id);
        stack_top++;
      end
    end
    return slot_h[id];
  endfunction

  function automatic answer_t predict_stack_command(mode_t m, logic [3:0] id,
                                                    logic signed [5:0] rq);
    answer_t a;
    int      req;
    int      fin;
    bit      found;
    req   = int'(rq);
    fin   = -1;
    found = 1'b0;
    a.st  = ST_OK;
    a.lyr = '0;
    case (m)
      MODE_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !taken[i]) begin
            taken[i]  = SLOT_TAKEN;
            slot_h[i] = -1;
            a.lyr     = 4'(i);
            found     = 1'b1;
          end
        end
        if (!found) a.st = ST_EMPTY;
      end
      MODE_SET: begin
        if (!taken[id]) a.st = ST_NOT_ALLOC;
        else fin = restack(id, req);
      end
      MODE_FREE: begin
        if (!taken[id]) begin
          a.st = ST_NOT_ALLOC;
        end else begin
          if (slot_h[id] >= 0) void'(restack(id, -1));
          taken[id] = 1'b0;
        end
      end
      default: begin
        if (req < 0 || req > stack_top) begin
          a.st = ST_EMPTY;
        end else begin
          a.lyr = z_order[req];
          fin   = req;
        end
      end
    endcase
    a.fin_h = 5'(fin);
    a.top_h = 5'(stack_top);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        z_order[i] = '0;
        slot_h[i]  = -1;
        taken[i]   = 1'b0;
      end
      stack_top = -1;
      pending_answers.delete();
      errs      = 0;
      n_checked = 0;
      deepest   = 0;
    end else begin
      // The result leaving now always belongs to an older item than the one
      // that may be accepted at this same edge, so compare first.
      if (done) begin
        if (pending_answers.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] unexpected result: status %0d layer %0d height %0d top %0d",
                     $time, status, result_layer, final_height, top_height);
        end else begin
          want = pending_answers.pop_front();
          n_checked++;
          if (status !== want.st || result_layer !== want.lyr ||
              final_height !== want.fin_h || top_height !== want.top_h) begin
            errs++;
            if (errs <= 10)
              $display({"[%0t] mismatch: expected status %0d layer %0d height %0d top %0d,",
                        " got status %0d layer %0d height %0d top %0d"},
                       $time, want.st, want.lyr, want.fin_h, want.top_h,
                       status, result_layer, final_height, top_height);
          end
        end
      end
      if (start && !busy) begin
        pending_answers.push_back(predict_stack_command(mode_t'(mode), layer_id, req_height));
        if (stack_top + 1 > deepest) deepest = stack_top + 1;
      end
    end
    fail_count <= errs;
    waiting    <= pending_answers.size();
    checked    <= n_checked;
    peak_depth <= deepest;
  end

endmodule

// ----- sim/layer_stack_manager_tb.sv -----
module layer_stack_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsm_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic [1:0]        mode;
  logic [3:0]        layer_id;
  logic signed [5:0] req_height;
  logic              busy;
  logic              done;
  logic [1:0]        status;
  logic [3:0]        result_layer;
  logic signed [4:0] final_height;
  logic signed [4:0] top_height;

  int fail_count;
  int waiting;
  int checked;
  int peak_depth;
  int cycles = 0;
  int sent;
  bit quiet;

  layer_stack_manager i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .layer_id     (layer_id),
    .req_height   (req_height),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_layer (result_layer),
    .final_height (final_height),
    .top_height   (top_height)
  );

  layer_stack_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .layer_id     (layer_id),
    .req_height   (req_height),
    .done         (done),
    .status       (status),
    .result_layer (result_layer),
    .final_height (final_height),
    .top_height   (top_height),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .checked      (checked),
    .peak_depth   (peak_depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Holds one command on the inputs until it is taken, then idles for a
  // random number of cycles unless a burst is running.
  task automatic issue(mode_t m, int id, int h);
    int gap;
    mode       <= m;
    layer_id   <= 4'(id);
    req_height <= 6'(h);
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int    pick;
    int    grow_w;
    int    free_w;
    int    h;
    int    n_directed;
    mode_t m;

    rst        = 1'b1;
    start      = 1'b0;
    mode       = MODE_ALLOC;
    layer_id   = '0;
    req_height = '0;
    sent       = 0;
    quiet      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty pool: nothing to read, nothing to move or release.
    issue(MODE_READ, 0, 0);
    issue(MODE_SET, 5, 3);
    issue(MODE_FREE, 15, 0);
    for (int i = 0; i < 16; i++) issue(MODE_ALLOC, i, -32);
    issue(MODE_ALLOC, 0, 0);
    // A hidden layer clamps to one above the top, a visible one to the top.
    issue(MODE_SET, 0, 31);
    issue(MODE_SET, 1, 0);
    issue(MODE_SET, 2, 31);
    issue(MODE_SET, 0, 31);
    issue(MODE_SET, 0, 2);
    issue(MODE_SET, 3, -32);
    issue(MODE_SET, 1, -5);
    issue(MODE_READ, 15, -1);
    issue(MODE_READ, 0, -32);
    issue(MODE_READ, 0, 31);
    issue(MODE_READ, 0, 1);
    issue(MODE_FREE, 2, 0);
    issue(MODE_FREE, 4, 0);
    issue(MODE_ALLOC, 0, 0);
    issue(MODE_SET, 0, -1);
    n_directed = sent;

    // Alternate between stretches that fill the pool and ones that drain it,
    // so the stack is often deep and sometimes empty.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      grow_w = ((n / 200) % 2 == 0) ? 22 : 8;
      free_w = ((n / 200) % 2 == 0) ? 6 : 20;
      pick   = $urandom_range(0, 99);
      h      = $urandom_range(0, 63) - 32;
      if (pick < grow_w) begin
        m = MODE_ALLOC;
      end else if (pick < grow_w + free_w) begin
        m = MODE_FREE;
      end else if (pick < grow_w + free_w + 45) begin
        m = MODE_SET;
        pick = $urandom_range(0, 9);
        if (pick == 1) h = -1;
        else if (pick > 1) h = $urandom_range(0, 16);
      end else begin
        m = MODE_READ;
        if ($urandom_range(0, 9) != 0) h = $urandom_range(0, 15);
      end
      issue(m, $urandom_range(0, 15), h);
    end
    start <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Issued %0d commands (%0d directed, rest random), %0d results compared.",
             sent, n_directed, checked);
    $display("Stack reached a depth of %0d visible layers.", peak_depth);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
